// ===== rtl/stop_and_wait_parity_sender_unit_macros.svh =====
// assertion macros for the stop-and-wait parity sender
`ifndef STOP_AND_WAIT_PARITY_SENDER_UNIT_MACROS_SVH
`define STOP_AND_WAIT_PARITY_SENDER_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define SWPS_ASSERT_NOW(label, clock, rstn, ante, cons) \
  label: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("swps assertion failed");

// next-cycle implication, disabled while reset is held
`define SWPS_ASSERT_NEXT(label, clock, rstn, ante, cons) \
  label: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("swps assertion failed");

`endif

// ===== rtl/swps_pkg.sv =====
// types and constants shared by the stop-and-wait parity sender
`timescale 1ns / 1ps
`default_nettype none

package swps_pkg;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_END     = 2'd1,
    KIND_REPLY   = 2'd2,
    KIND_TIMEOUT = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_FIRST  = 3'd0,
    ST_RESEND = 3'd1,
    ST_ACKED  = 3'd2,
    ST_FAILED = 3'd3,
    ST_REJECT = 3'd4,
    ST_DONE   = 3'd5
  } status_t;

  localparam logic [7:0] ACK_CODE         = 8'd1;
  localparam logic [2:0] RESEND_LIMIT_RST = 3'd3;

  // session state carried between words
  typedef struct packed {
    logic       awaiting;
    logic [7:0] seq;
    logic [7:0] held_data;
    logic       held_end;
    logic [2:0] retries;
  } state_t;

  // one result word
  typedef struct packed {
    logic       frame_valid;
    logic [7:0] frame_seq;
    logic [7:0] frame_data;
    logic       frame_parity;
    logic       frame_is_end;
    logic [2:0] status;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/swps_if.sv =====
// valid/ready channel interfaces for the input and result words
`timescale 1ns / 1ps
`default_nettype none

interface swps_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [7:0] reply_byte;

  modport source (output valid, kind, data_byte, reply_byte, input ready);
  modport sink (input valid, kind, data_byte, reply_byte, output ready);
endinterface

interface swps_out_if;
  logic       valid;
  logic       ready;
  logic       frame_valid;
  logic [7:0] frame_seq;
  logic [7:0] frame_data;
  logic       frame_parity;
  logic       frame_is_end;
  logic [2:0] status;

  modport source (output valid, frame_valid, frame_seq, frame_data, frame_parity,
                  frame_is_end, status, input ready);
  modport sink (input valid, frame_valid, frame_seq, frame_data, frame_parity,
                frame_is_end, status, output ready);
endinterface

`default_nettype wire

// ===== rtl/swps_step.sv =====
// next-state and result logic for one word of the sender
`timescale 1ns / 1ps
`default_nettype none

module swps_step (
  input  swps_pkg::state_t  st,
  input  logic [2:0]        resend_limit,
  input  logic [1:0]        kind,
  input  logic [7:0]        data_byte,
  input  logic [7:0]        reply_byte,
  output swps_pkg::state_t  st_nxt,
  output swps_pkg::result_t res
);

  logic send;

  always_comb begin
    st_nxt     = st;
    send       = 1'b0;
    res.status = swps_pkg::ST_REJECT;
    case (swps_pkg::kind_t'(kind))
      swps_pkg::KIND_DATA, swps_pkg::KIND_END: begin
        if (!st.awaiting) begin
          st_nxt.held_end  = (kind == swps_pkg::KIND_END);
          st_nxt.held_data = (kind == swps_pkg::KIND_END) ? 8'd0 : data_byte;
          st_nxt.retries   = 3'd0;
          st_nxt.awaiting  = 1'b1;
          send             = 1'b1;
          res.status       = swps_pkg::ST_FIRST;
        end
      end
      swps_pkg::KIND_REPLY, swps_pkg::KIND_TIMEOUT: begin
        if (st.awaiting) begin
          if (kind == swps_pkg::KIND_REPLY && reply_byte == swps_pkg::ACK_CODE) begin
            st_nxt.awaiting = 1'b0;
            st_nxt.retries  = 3'd0;
            if (st.held_end) begin
              st_nxt.seq = 8'd0;
              res.status = swps_pkg::ST_DONE;
            end else begin
              st_nxt.seq = st.seq + 8'd1;
              res.status = swps_pkg::ST_ACKED;
            end
          end else if (st.retries < resend_limit) begin
            // nak or timeout with budget left
            st_nxt.retries = st.retries + 3'd1;
            send           = 1'b1;
            res.status     = swps_pkg::ST_RESEND;
          end else begin
            st_nxt.awaiting = 1'b0;
            st_nxt.retries  = 3'd0;
            st_nxt.seq      = 8'd0;
            res.status      = swps_pkg::ST_FAILED;
          end
        end
      end
      default: begin
        res.status = swps_pkg::ST_REJECT;
      end
    endcase

    // a sent frame carries the held contents after this word; with no send all frame fields are zero
    res.frame_valid  = send;
    res.frame_seq    = send ? st.seq : 8'd0;
    res.frame_data   = send ? st_nxt.held_data : 8'd0;
    res.frame_parity = send ? (^st_nxt.held_data) : 1'b0;
    res.frame_is_end = send ? st_nxt.held_end : 1'b0;
  end

endmodule

`default_nettype wire

// ===== rtl/stop_and_wait_parity_sender_unit.sv =====
// top level of the stop-and-wait sender with even-parity frames
// usage:
//   in_word  : one word per event: kind (data byte, end marker, reply, timeout),
//              data_byte and reply_byte; taken when valid and ready are high
//   out_word : one result word per input word: frame fields and a status code
//   cfg_we / cfg_wdata : write the resend limit, the resends allowed per frame
// the result word is registered and shown in the cycle after its input word is taken
// throughput: one word per cycle while out_word.ready stays high; the output register frees in the same cycle
//   it is taken, so in_word.ready = !out_word.valid || out_word.ready
// the session state is read and written by a combinational update on each taken word, so words
//   follow each other back to back without a bubble
// reset: session idle, sequence zero, no result pending, resend limit back to 3
// receiver stall: the result stays in the output register and in_word.ready
//   drops until it is taken; no word is lost or repeated
// config is to be written by the user only while the block is idle; the block does not enforce this
`timescale 1ns / 1ps
`default_nettype none
`include "stop_and_wait_parity_sender_unit_macros.svh"

module stop_and_wait_parity_sender_unit (
  input  logic              clk,
  input  logic              rst_n,
  swps_in_if.sink           in_word,
  swps_out_if.source        out_word,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_wdata
);

  // retry budget register
  logic [2:0] resend_limit_r;

  // session state
  swps_pkg::state_t state_r;
  swps_pkg::state_t state_nxt;

  // result register, payload needs no reset
  logic              out_valid_r;
  swps_pkg::result_t res_r;
  swps_pkg::result_t res_nxt;

  logic accept;

  // terms for the checks below
  logic no_frame;
  logic sent_frame;
  logic frame_zero;
  logic parity_ok;
  logic opens_frame;
  logic armed_first;

  assign in_word.ready = !out_valid_r || out_word.ready;
  assign accept        = in_word.valid && in_word.ready;

  swps_step u_step (
    .st           (state_r),
    .resend_limit (resend_limit_r),
    .kind         (in_word.kind),
    .data_byte    (in_word.data_byte),
    .reply_byte   (in_word.reply_byte),
    .st_nxt       (state_nxt),
    .res          (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resend_limit_r <= swps_pkg::RESEND_LIMIT_RST;
    end else if (cfg_we) begin
      resend_limit_r <= cfg_wdata;
    end
  end

  // state moves only on a taken word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_word.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_word.valid        = out_valid_r;
  assign out_word.frame_valid  = res_r.frame_valid;
  assign out_word.frame_seq    = res_r.frame_seq;
  assign out_word.frame_data   = res_r.frame_data;
  assign out_word.frame_parity = res_r.frame_parity;
  assign out_word.frame_is_end = res_r.frame_is_end;
  assign out_word.status       = res_r.status;

  assign no_frame    = out_valid_r && !res_r.frame_valid;
  assign sent_frame  = out_valid_r && res_r.frame_valid;
  assign frame_zero  = res_r.frame_seq == 8'd0 && res_r.frame_data == 8'd0 &&
                       !res_r.frame_parity && !res_r.frame_is_end;
  assign parity_ok   = res_r.frame_parity == (^res_r.frame_data);
  assign opens_frame = accept && !state_r.awaiting &&
                       (in_word.kind == swps_pkg::KIND_DATA ||
                        in_word.kind == swps_pkg::KIND_END);
  assign armed_first = state_r.awaiting && out_valid_r &&
                       res_r.status == swps_pkg::ST_FIRST;

  // no frame means all frame fields are zero
  `SWPS_ASSERT_NOW(a_idle_frame_zero, clk, rst_n, no_frame, frame_zero)

  // a sent frame carries even parity over its data
  `SWPS_ASSERT_NOW(a_frame_parity, clk, rst_n, sent_frame, parity_ok)

  // a data or end word taken while idle arms the reply wait
  `SWPS_ASSERT_NEXT(a_send_arms, clk, rst_n, opens_frame, armed_first)

endmodule

`default_nettype wire
